/* hdl/rgb4_pkg.sv */
// ----------------------------------------------------------------------------
// rgb4_pkg
// Shared types and constants of the four-tap RGB average filter.
// ----------------------------------------------------------------------------
package rgb4_pkg;

    // Line store depth and derived address width
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);

    // Configuration register widths and reset values
    localparam int CFG_W        = 13;
    localparam int PADDR_W      = 3;
    localparam int PIX_W        = 24;
    localparam int COORD_W      = 12;
    localparam int RES_SLOTS    = 3;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    // Register indexes (taken from paddr[2])
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic [ADDR_W-1:0]  t_col;
    typedef logic [COORD_W-1:0] t_row;
    typedef logic [PIX_W-1:0]   t_pix;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_pix_in;

    typedef struct packed {
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic [COORD_W-1:0] pixel_column;
        logic [COORD_W-1:0] pixel_row;
        logic               run_last;
    } t_pix_out;

    // Frame geometry after clamping, plus restart strobe on a register write
    typedef struct packed {
        logic [CFG_W-1:0] width_eff;
        logic [CFG_W-1:0] height_eff;
        logic             restart;
    } t_frame_cfg;

    // Up to three results of one request, in emission order
    typedef struct packed {
        logic [RES_SLOTS-1:0] mask;
        t_pix_out             item2;
        t_pix_out             item1;
        t_pix_out             item0;
    } t_res_set;

endpackage

/* hdl/rgb4_ram.sv */
// ----------------------------------------------------------------------------
// rgb4_ram
// Generic single-clock RAM, one write port, one registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module rgb4_ram #(
    parameter int  WIDTH = 24,
    parameter int  DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read; read data holds when no read is enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* hdl/rgb4_cfg.sv */
// ----------------------------------------------------------------------------
// rgb4_cfg
// APB-style register file for frame width and height, with clamping.
// ----------------------------------------------------------------------------
module rgb4_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rgb4_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output rgb4_pkg::t_frame_cfg        o_cfg
);
    import rgb4_pkg::*;

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    // Hold the register values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[CFG_W-1:0];
                default:          r_frame_width  <= r_frame_width;
            endcase
        end
    end

    // Read back the raw register
    assign prdata = (reg_sel == REG_FRAME_HEIGHT) ? 32'(r_frame_height)
                                                  : 32'(r_frame_width);

    // Clamp geometry to one at zero and to MAX_WIDTH / MAX_HEIGHT at the top
    always_comb begin
        if (r_frame_width == '0) begin
            o_cfg.width_eff = CFG_W'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            o_cfg.width_eff = CFG_W'(MAX_WIDTH);
        end else begin
            o_cfg.width_eff = r_frame_width;
        end
        if (r_frame_height == '0) begin
            o_cfg.height_eff = CFG_W'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            o_cfg.height_eff = CFG_W'(MAX_HEIGHT);
        end else begin
            o_cfg.height_eff = r_frame_height;
        end
        o_cfg.restart = wr_en;
    end

endmodule

/* hdl/rgb4_result_buf.sv */
// ----------------------------------------------------------------------------
// rgb4_result_buf
// Output register for one request's results; emits one a cycle unless stalled.
// ----------------------------------------------------------------------------
module rgb4_result_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  rgb4_pkg::t_res_set i_set,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_stall,
    output rgb4_pkg::t_pix_out o_result
);
    import rgb4_pkg::*;

    logic [RES_SLOTS-1:0] r_mask;
    t_pix_out             r_item0;
    t_pix_out             r_item1;
    t_pix_out             r_item2;
    logic [RES_SLOTS-1:0] rest_mask;
    logic                 take;

    assign o_valid   = |r_mask;
    assign take      = o_valid && !i_stall;
    assign rest_mask = r_mask & (r_mask - 1'b1);
    assign o_ready   = !o_valid || (take && (rest_mask == '0));

    // Load a new set, or drop the result just taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_load) begin
            r_mask <= i_set.mask;
        end else if (take) begin
            r_mask <= rest_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item0 <= i_set.item0;
            r_item1 <= i_set.item1;
            r_item2 <= i_set.item2;
        end
    end

    // Present the earliest pending result; mark the final one
    always_comb begin
        priority if (r_mask[0]) begin
            o_result = r_item0;
        end else if (r_mask[1]) begin
            o_result = r_item1;
        end else begin
            o_result = r_item2;
        end
        o_result.run_last = (rest_mask == '0);
    end

endmodule

/* hdl/rgb_four_tap_average_filter_top.sv */
// ----------------------------------------------------------------------------
// rgb_four_tap_average_filter_top
// Streaming four-pixel average smoothing filter over RGB raster frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_pixel) takes one RGB pixel per request
//   in raster order. Output channel (o_valid / i_stall / o_result) gives the
//   smoothed or passed-through pixels with their column and row; run_last
//   marks the final result caused by one input pixel (zero to three results).
//   The APB-style port holds frame_width at 0x0 and frame_height at 0x4; a
//   write restarts the frame at column 0, row 0. Write it only while idle.
// Timing: the accept edge reads the line store and loads the read stage; the
//   result register loads from the read stage once it is ready, and the
//   result leaves from there when the receiver does not stall.
// Throughput: one pixel per cycle while each pixel causes at most one result
//   and no stall; a pixel with more results holds the result register until
//   all are taken, which sets the rate at row ends and in the last row.
// Reset: counters and pipeline clear, geometry returns to 640 x 480; the line
//   store is not cleared and holds no meaning until the first row is written.
// Stall: a stalled receiver holds the result register; the read stage then
//   holds, and o_stall rises so the source holds its pixel.
// ----------------------------------------------------------------------------
module rgb_four_tap_average_filter_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  rgb4_pkg::t_pix_in            i_pixel,
    output logic                         o_valid,
    input  logic                         i_stall,
    output rgb4_pkg::t_pix_out           o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rgb4_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import rgb4_pkg::*;

    // Per-channel truncated quarter of a four-pixel sum
    function automatic t_pix average4(t_pix a, t_pix b, t_pix c, t_pix d);
        t_pix       res;
        logic [9:0] s;
        for (int k = 0; k < 3; k++) begin
            s = 10'(a[k*8 +: 8]) + 10'(b[k*8 +: 8]) + 10'(c[k*8 +: 8]) + 10'(d[k*8 +: 8]);
            res[k*8 +: 8] = s[9:2];
        end
        return res;
    endfunction

    t_frame_cfg cfg;
    t_res_set   res_set;
    t_pix       ram_rdata;
    t_pix       cur_pix;
    t_pix       pix0;
    logic       accept_in;
    logic       s1_adv;
    logic       buf_ready;
    logic       last_col;
    logic       last_row;

    // Position of the next input pixel
    t_col r_col;
    t_row r_row;

    // Read stage
    logic r_s1_valid;
    t_pix r_s1_cur;
    t_col r_s1_col;
    t_row r_s1_row;
    logic r_s1_last_col;
    logic r_s1_emit_cur;
    logic r_s1_ge2;

    // Row above at columns c-1 and c-2, and previous pixel of this row
    t_pix r_upper_near;
    t_pix r_upper_far;
    t_pix r_left;

    rgb4_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign cur_pix   = {i_pixel.in_red, i_pixel.in_green, i_pixel.in_blue};
    assign s1_adv    = r_s1_valid && buf_ready;
    assign o_stall   = r_s1_valid && !buf_ready;
    assign accept_in = i_valid && !o_stall;
    assign last_col  = (32'(r_col) == 32'(cfg.width_eff) - 32'd1);
    assign last_row  = (32'(r_row) == 32'(cfg.height_eff) - 32'd1);

    // Line store: read the row above and write this pixel at the same edge
    rgb4_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (accept_in),
        .i_waddr (r_col),
        .i_wdata (cur_pix),
        .i_re    (accept_in),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // Advance column and row counters; restart on a register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg.restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept_in) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : t_row'(r_row + 1'b1);
            end else begin
                r_col <= t_col'(r_col + 1'b1);
            end
        end
    end

    // Hold the request in the read stage until the result register takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept_in) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1_cur      <= cur_pix;
            r_s1_col      <= r_col;
            r_s1_row      <= r_row;
            r_s1_last_col <= last_col;
            r_s1_emit_cur <= (r_row == '0) || last_row;
            r_s1_ge2      <= (r_row >= t_row'(2));
        end
    end

    // Shift the row-above window and the left pixel as each request retires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg.restart) begin
            r_upper_near <= '0;
            r_upper_far  <= '0;
            r_left       <= '0;
        end else if (s1_adv) begin
            r_upper_far  <= r_upper_near;
            r_upper_near <= ram_rdata;
            r_left       <= r_s1_last_col ? '0 : r_s1_cur;
        end
    end

    // Build the results of the request in the read stage
    assign pix0 = (r_s1_col == t_col'(1)) ? r_upper_near
                : average4(r_upper_near, r_upper_far, r_left, r_s1_cur);

    always_comb begin
        res_set.mask[0] = r_s1_ge2 && (r_s1_col != '0);
        res_set.mask[1] = r_s1_ge2 && r_s1_last_col;
        res_set.mask[2] = r_s1_emit_cur;

        res_set.item0.out_red      = pix0[23:16];
        res_set.item0.out_green    = pix0[15:8];
        res_set.item0.out_blue     = pix0[7:0];
        res_set.item0.pixel_column = COORD_W'(t_col'(r_s1_col - 1'b1));
        res_set.item0.pixel_row    = t_row'(r_s1_row - 1'b1);
        res_set.item0.run_last     = 1'b0;

        res_set.item1.out_red      = ram_rdata[23:16];
        res_set.item1.out_green    = ram_rdata[15:8];
        res_set.item1.out_blue     = ram_rdata[7:0];
        res_set.item1.pixel_column = COORD_W'(r_s1_col);
        res_set.item1.pixel_row    = t_row'(r_s1_row - 1'b1);
        res_set.item1.run_last     = 1'b0;

        res_set.item2.out_red      = r_s1_cur[23:16];
        res_set.item2.out_green    = r_s1_cur[15:8];
        res_set.item2.out_blue     = r_s1_cur[7:0];
        res_set.item2.pixel_column = COORD_W'(r_s1_col);
        res_set.item2.pixel_row    = r_s1_row;
        res_set.item2.run_last     = 1'b0;
    end

    rgb4_result_buf u_result_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s1_adv),
        .i_set    (res_set),
        .o_ready  (buf_ready),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

endmodule
